[hw/rtl/cnv_pkg.sv]
// Shared constants, types and codes for the 5x5 streaming convolution block.
// No dependencies; every other file in hw/rtl except cnv_ram refers to this package.
`default_nettype none

package cnv_pkg;

   localparam int KERNEL_SIZE = 5;
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int KK          = KERNEL_SIZE * KERNEL_SIZE;
   localparam int LINES       = KERNEL_SIZE - 1;

   localparam int PIX_W      = 16;
   localparam int PROD_W     = 2 * PIX_W;
   localparam int ROW_SUM_W  = PROD_W + $clog2(KERNEL_SIZE);
   localparam int ACC_W      = PROD_W + $clog2(KK) + 1;
   localparam int LINE_W     = LINES * PIX_W;
   localparam int FRAC_DROP  = 14;
   localparam int ROUND_HALF = 1 << (FRAC_DROP - 1);

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int POS_W      = 8;
   localparam int IDX_W      = 5;
   localparam int KK_IDX_W   = $clog2(KK);
   localparam int DIM_W      = 9;
   localparam int BIAS_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // wide enough for counters plus one and for the size registers
   localparam int CMP_A_W = (COL_W > ROW_W) ? COL_W + 1 : ROW_W + 1;
   localparam int CMP_W   = (CMP_A_W > DIM_W) ? CMP_A_W : DIM_W;

   localparam int WIDTH_RESET  = 32;
   localparam int HEIGHT_RESET = 32;

   typedef enum logic {
      MODE_COEF  = 1'b0,
      MODE_PIXEL = 1'b1
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_BIAS   = 2'd2
   } csr_index_type;

   typedef logic signed [PIX_W-1:0]     sample_type;
   typedef logic signed [PROD_W-1:0]    prod_type;
   typedef prod_type [KK-1:0]           prod_arr_type;
   typedef logic signed [ROW_SUM_W-1:0] row_sum_type;
   typedef logic signed [ACC_W-1:0]     acc_type;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
   } cnv_meta_type;

endpackage

`default_nettype wire

[hw/rtl/cnv_req_if.sv]
// Request channel: valid/ready handshake with mode, coefficient index and value.
// Depends on cnv_pkg for field widths.
`default_nettype none

interface cnv_req_if;
   logic                           valid;
   logic                           ready;
   logic                           mode;
   logic [cnv_pkg::IDX_W-1:0]      coeff_index;
   logic signed [cnv_pkg::PIX_W-1:0] value;

   modport source (output valid, output mode, output coeff_index, output value,
                   input ready);
   modport sink   (input valid, input mode, input coeff_index, input value,
                   output ready);
endinterface

`default_nettype wire

[hw/rtl/cnv_rsp_if.sv]
// Response channel: valid/ready handshake with result, output position and last flag.
// Depends on cnv_pkg for field widths.
`default_nettype none

interface cnv_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [cnv_pkg::PIX_W-1:0] result;
   logic [cnv_pkg::POS_W-1:0]        out_row;
   logic [cnv_pkg::POS_W-1:0]        out_col;
   logic                             last;

   modport source (output valid, output result, output out_row, output out_col,
                   output last, input ready);
   modport sink   (input valid, input result, input out_row, input out_col,
                   input last, output ready);
endinterface

`default_nettype wire

[hw/rtl/cnv_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No package dependency.
`default_nettype none

module cnv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/cnv_front.sv]
// Front end: frame counters, line store, 5x5 window, coefficients and product stage.
// Depends on cnv_pkg, cnv_req_if and cnv_ram.
`default_nettype none

module cnv_front (
   input  logic                         clock,
   input  logic                         reset,
   cnv_req_if.sink                      req,
   input  logic [cnv_pkg::CMP_W-1:0]    width_eff,
   input  logic [cnv_pkg::CMP_W-1:0]    height_eff,
   output logic                         prod_valid,
   input  logic                         prod_ready,
   output cnv_pkg::prod_arr_type        prod_data,
   output cnv_pkg::cnv_meta_type        prod_meta
);

   localparam int K = cnv_pkg::KERNEL_SIZE;

   // frame position
   logic [cnv_pkg::COL_W-1:0] col_cnt_ff, col_cnt_in;
   logic [cnv_pkg::ROW_W-1:0] row_cnt_ff, row_cnt_in;

   // stage 1: accepted request, line store read in flight
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_mode_ff;
   logic [cnv_pkg::IDX_W-1:0]     s1_idx_ff;
   cnv_pkg::sample_type           s1_value_ff;
   logic [cnv_pkg::COL_W-1:0]     s1_x_ff;
   logic                          s1_emit_ff;
   cnv_pkg::cnv_meta_type         s1_meta_ff;

   // stage 2: registered products
   logic                          prod_valid_ff, prod_valid_in;
   cnv_pkg::prod_arr_type         prod_data_ff, prod_data_in;
   cnv_pkg::cnv_meta_type         prod_meta_ff;

   cnv_pkg::sample_type coef_ff [cnv_pkg::KK];
   cnv_pkg::sample_type coef_in [cnv_pkg::KK];
   cnv_pkg::sample_type win_ff  [K][K];
   cnv_pkg::sample_type win_in  [K][K];
   cnv_pkg::sample_type col_new [K];

   logic [cnv_pkg::LINE_W-1:0] line_rd;
   logic [cnv_pkg::LINE_W-1:0] line_wr;

   logic                      accept;
   logic                      s2_free;
   logic                      s1_fire;
   logic                      s1_pixel;
   logic [cnv_pkg::CMP_W-1:0] x_ext, y_ext;
   logic                      eor, eof, emit;
   cnv_pkg::cnv_meta_type     meta_new;

   assign s2_free   = !prod_valid_ff || prod_ready;
   assign req.ready = !s1_valid_ff || s2_free;
   assign accept    = req.valid && req.ready;
   assign s1_fire   = s1_valid_ff && s2_free;
   assign s1_pixel  = (s1_mode_ff == cnv_pkg::MODE_PIXEL);

   // position of the incoming pixel
   always_comb begin
      x_ext = cnv_pkg::CMP_W'(col_cnt_ff);
      y_ext = cnv_pkg::CMP_W'(row_cnt_ff);
      eor   = (x_ext + cnv_pkg::CMP_W'(1)) >= width_eff;
      eof   = eor && ((y_ext + cnv_pkg::CMP_W'(1)) >= height_eff);
      emit  = (x_ext >= cnv_pkg::CMP_W'(K - 1)) && (y_ext >= cnv_pkg::CMP_W'(K - 1));

      meta_new.row  = cnv_pkg::POS_W'(row_cnt_ff - cnv_pkg::ROW_W'(K - 1));
      meta_new.col  = cnv_pkg::POS_W'(col_cnt_ff - cnv_pkg::COL_W'(K - 1));
      meta_new.last = eof;

      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (accept && (req.mode == cnv_pkg::MODE_PIXEL)) begin
         if (eor) begin
            col_cnt_in = '0;
            if ((y_ext + cnv_pkg::CMP_W'(1)) >= height_eff) begin
               row_cnt_in = '0;
            end else begin
               row_cnt_in = row_cnt_ff + cnv_pkg::ROW_W'(1);
            end
         end else begin
            col_cnt_in = col_cnt_ff + cnv_pkg::COL_W'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req.ready) begin
         s1_valid_in = accept;
      end
      prod_valid_in = prod_valid_ff;
      if (s2_free) begin
         prod_valid_in = s1_fire && s1_pixel && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff    <= '0;
         row_cnt_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         col_cnt_ff    <= col_cnt_in;
         row_cnt_ff    <= row_cnt_in;
         s1_valid_ff   <= s1_valid_in;
         prod_valid_ff <= prod_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff  <= req.mode;
         s1_idx_ff   <= req.coeff_index;
         s1_value_ff <= req.value;
         s1_x_ff     <= col_cnt_ff;
         s1_emit_ff  <= emit;
         s1_meta_ff  <= meta_new;
      end
   end

   // line store: one word per column holds the previous rows, oldest in the low slice
   cnv_ram #(
      .WIDTH(cnv_pkg::LINE_W),
      .DEPTH(cnv_pkg::MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_fire && s1_pixel),
      .wr_addr (s1_x_ff),
      .wr_data (line_wr),
      .rd_en   (accept),
      .rd_addr (col_cnt_ff),
      .rd_data (line_rd)
   );

   always_comb begin
      for (int k = 0; k < cnv_pkg::LINES; k++) begin
         col_new[k] = line_rd[k*cnv_pkg::PIX_W +: cnv_pkg::PIX_W];
      end
      col_new[K-1] = s1_value_ff;
      // drop the oldest row, push the new pixel
      for (int k = 0; k < cnv_pkg::LINES; k++) begin
         line_wr[k*cnv_pkg::PIX_W +: cnv_pkg::PIX_W] = col_new[k+1];
      end
   end

   // window shifts left by one column; products use the shifted window
   always_comb begin
      for (int r = 0; r < K; r++) begin
         for (int c = 0; c < K - 1; c++) begin
            win_in[r][c] = win_ff[r][c+1];
         end
         win_in[r][K-1] = col_new[r];
      end
      for (int r = 0; r < K; r++) begin
         for (int c = 0; c < K; c++) begin
            prod_data_in[r*K + c] = win_in[r][c] * coef_ff[r*K + c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_pixel) begin
         win_ff <= win_in;
      end
      if (s1_fire) begin
         prod_data_ff <= prod_data_in;
         prod_meta_ff <= s1_meta_ff;
      end
   end

   // coefficient load; an index past the kernel matches no entry
   always_comb begin
      for (int i = 0; i < cnv_pkg::KK; i++) begin
         coef_in[i] = coef_ff[i];
         if (s1_fire && !s1_pixel && (s1_idx_ff == cnv_pkg::IDX_W'(i))) begin
            coef_in[i] = s1_value_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cnv_pkg::KK; i++) begin
            coef_ff[i] <= '0;
         end
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign prod_valid = prod_valid_ff;
   assign prod_data  = prod_data_ff;
   assign prod_meta  = prod_meta_ff;

endmodule

`default_nettype wire

[hw/rtl/cnv_sum.sv]
// Back end: row sums, total with bias, rounding to Q4.12 with saturation, output register.
// Depends on cnv_pkg and cnv_rsp_if.
`default_nettype none

module cnv_sum (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  cnv_pkg::prod_arr_type       in_data,
   input  cnv_pkg::cnv_meta_type       in_meta,
   input  logic [cnv_pkg::BIAS_W-1:0]  bias,
   cnv_rsp_if.source                   rsp
);

   localparam int K = cnv_pkg::KERNEL_SIZE;
   localparam cnv_pkg::acc_type SAT_HI = cnv_pkg::ACC_W'(2**(cnv_pkg::PIX_W-1) - 1);
   localparam cnv_pkg::acc_type SAT_LO = cnv_pkg::ACC_W'(-(2**(cnv_pkg::PIX_W-1)));

   logic                  a_valid_ff, a_valid_in;
   cnv_pkg::row_sum_type  a_sum_ff [K];
   cnv_pkg::row_sum_type  a_sum_in [K];
   cnv_pkg::cnv_meta_type a_meta_ff;

   logic                  b_valid_ff, b_valid_in;
   cnv_pkg::acc_type      b_acc_ff, b_acc_in;
   cnv_pkg::cnv_meta_type b_meta_ff;

   logic                  out_valid_ff, out_valid_in;
   cnv_pkg::sample_type   out_result_ff, out_result_in;
   cnv_pkg::cnv_meta_type out_meta_ff;

   logic             out_free, b_free, a_free;
   cnv_pkg::acc_type rounded;
   cnv_pkg::acc_type scaled;

   assign out_free = !out_valid_ff || rsp.ready;
   assign b_free   = !b_valid_ff || out_free;
   assign a_free   = !a_valid_ff || b_free;
   assign in_ready = a_free;

   always_comb begin
      for (int r = 0; r < K; r++) begin
         a_sum_in[r] = '0;
         for (int c = 0; c < K; c++) begin
            a_sum_in[r] = a_sum_in[r]
                        + cnv_pkg::ROW_SUM_W'($signed(in_data[r*K + c]));
         end
      end
   end

   always_comb begin
      b_acc_in = cnv_pkg::ACC_W'($signed(bias));
      for (int r = 0; r < K; r++) begin
         b_acc_in = b_acc_in + cnv_pkg::ACC_W'(a_sum_ff[r]);
      end
   end

   // round half up, then clamp to the 16-bit range
   always_comb begin
      rounded = b_acc_ff + cnv_pkg::ACC_W'(cnv_pkg::ROUND_HALF);
      scaled  = rounded >>> cnv_pkg::FRAC_DROP;
      if (scaled > SAT_HI) begin
         out_result_in = SAT_HI[cnv_pkg::PIX_W-1:0];
      end else if (scaled < SAT_LO) begin
         out_result_in = SAT_LO[cnv_pkg::PIX_W-1:0];
      end else begin
         out_result_in = scaled[cnv_pkg::PIX_W-1:0];
      end
   end

   always_comb begin
      a_valid_in   = a_free   ? in_valid   : a_valid_ff;
      b_valid_in   = b_free   ? a_valid_ff : b_valid_ff;
      out_valid_in = out_free ? b_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_free && in_valid) begin
         a_sum_ff  <= a_sum_in;
         a_meta_ff <= in_meta;
      end
      if (b_free && a_valid_ff) begin
         b_acc_ff  <= b_acc_in;
         b_meta_ff <= a_meta_ff;
      end
      if (out_free && b_valid_ff) begin
         out_result_ff <= out_result_in;
         out_meta_ff   <= b_meta_ff;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.result  = out_result_ff;
   assign rsp.out_row = out_meta_ff.row;
   assign rsp.out_col = out_meta_ff.col;
   assign rsp.last    = out_meta_ff.last;

endmodule

`default_nettype wire

[hw/rtl/conv2d_5x5_valid_stream_unit.sv]
// Top level of the streaming 5x5 valid convolution: control registers and the two stages.
// Depends on cnv_pkg, cnv_req_if, cnv_rsp_if, cnv_front and cnv_sum.
//
// Usage:
//   req_ch carries requests: mode 0 loads kernel coefficient coeff_index (Q2.14),
//   mode 1 delivers the next pixel (Q4.12) of a raster-order frame.
//   rsp_ch returns one result per full 5x5 window: the Q4.12 sum plus bias, rounded
//   half up and saturated, with its output row and column; last marks the frame end.
//   csr_* writes image_width (0), image_height (1) and bias (2); sizes are clamped
//   to 5..256. Write only while no request is in flight.
// Timing:
//   One request per cycle, sustained while rsp_ch.ready is high. A result passes, once
//   its pixel is accepted, through line store read, multiply, row sums, total and round.
//   The line store is a single 256 x 64 RAM, read and written once per pixel.
// Reset:
//   Synchronous. Clears the frame counters, the coefficients, the pipeline valids and
//   restores 32 x 32 with zero bias. The line store is not cleared.
// Stalls:
//   Each stage holds while the one after it is full; the output register lets a new
//   request in while a result waits, and req_ch.ready drops only once all stages fill.
`default_nettype none

module conv2d_5x5_valid_stream_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [cnv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cnv_pkg::CSR_DATA_W-1:0]  csr_write_data,
   cnv_req_if.sink                         req_ch,
   cnv_rsp_if.source                       rsp_ch
);

   logic [cnv_pkg::DIM_W-1:0]  width_ff, width_in;
   logic [cnv_pkg::DIM_W-1:0]  height_ff, height_in;
   logic [cnv_pkg::BIAS_W-1:0] bias_ff, bias_in;

   logic [cnv_pkg::CMP_W-1:0] width_raw, height_raw;
   logic [cnv_pkg::CMP_W-1:0] width_eff, height_eff;

   logic                  prod_valid;
   logic                  prod_ready;
   cnv_pkg::prod_arr_type prod_data;
   cnv_pkg::cnv_meta_type prod_meta;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      bias_in   = bias_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            cnv_pkg::CSR_WIDTH:  width_in  = csr_write_data[cnv_pkg::DIM_W-1:0];
            cnv_pkg::CSR_HEIGHT: height_in = csr_write_data[cnv_pkg::DIM_W-1:0];
            cnv_pkg::CSR_BIAS:   bias_in   = csr_write_data[cnv_pkg::BIAS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= cnv_pkg::DIM_W'(cnv_pkg::WIDTH_RESET);
         height_ff <= cnv_pkg::DIM_W'(cnv_pkg::HEIGHT_RESET);
         bias_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         bias_ff   <= bias_in;
      end
   end

   // clamp the frame size to what the window and line store support
   always_comb begin
      width_raw  = cnv_pkg::CMP_W'(width_ff);
      height_raw = cnv_pkg::CMP_W'(height_ff);
      if (width_raw < cnv_pkg::CMP_W'(cnv_pkg::KERNEL_SIZE)) begin
         width_eff = cnv_pkg::CMP_W'(cnv_pkg::KERNEL_SIZE);
      end else if (width_raw > cnv_pkg::CMP_W'(cnv_pkg::MAX_WIDTH)) begin
         width_eff = cnv_pkg::CMP_W'(cnv_pkg::MAX_WIDTH);
      end else begin
         width_eff = width_raw;
      end
      if (height_raw < cnv_pkg::CMP_W'(cnv_pkg::KERNEL_SIZE)) begin
         height_eff = cnv_pkg::CMP_W'(cnv_pkg::KERNEL_SIZE);
      end else if (height_raw > cnv_pkg::CMP_W'(cnv_pkg::MAX_HEIGHT)) begin
         height_eff = cnv_pkg::CMP_W'(cnv_pkg::MAX_HEIGHT);
      end else begin
         height_eff = height_raw;
      end
   end

   cnv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod_data  (prod_data),
      .prod_meta  (prod_meta)
   );

   cnv_sum u_sum (
      .clock    (clock),
      .reset    (reset),
      .in_valid (prod_valid),
      .in_ready (prod_ready),
      .in_data  (prod_data),
      .in_meta  (prod_meta),
      .bias     (bias_ff),
      .rsp      (rsp_ch)
   );

endmodule

`default_nettype wire

[hw/rtl/cnv_checker.sv]
// Port-level checks for conv2d_5x5_valid_stream_unit, attached by the bind below.
// Depends on cnv_pkg and on the top level's port names.
`default_nettype none

module cnv_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [cnv_pkg::PIX_W-1:0]   rsp_result,
   input logic [cnv_pkg::POS_W-1:0]   rsp_out_row,
   input logic [cnv_pkg::POS_W-1:0]   rsp_out_col,
   input logic                        rsp_last
);

   localparam logic [cnv_pkg::POS_W-1:0] ROW_MAX =
      cnv_pkg::POS_W'(cnv_pkg::MAX_HEIGHT - cnv_pkg::KERNEL_SIZE);
   localparam logic [cnv_pkg::POS_W-1:0] COL_MAX =
      cnv_pkg::POS_W'(cnv_pkg::MAX_WIDTH - cnv_pkg::KERNEL_SIZE);

   // no result can reach the output before the pipeline has filled
   a_no_early_result: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("result appeared before the pipeline could fill");

   // a free output register must let a request in
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request blocked while the output side is free");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_row <= ROW_MAX) && (rsp_out_col <= COL_MAX))
      else $error("output position outside the valid area");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result)
         && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_last))
      else $error("stalled result changed");

   // req_valid is used here: a stalled result must stay valid while a request is taken
   a_req_seen: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("stalled result dropped while a request was taken");

endmodule

bind conv2d_5x5_valid_stream_unit cnv_checker u_cnv_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_result  (rsp_ch.result),
   .rsp_out_row (rsp_ch.out_row),
   .rsp_out_col (rsp_ch.out_col),
   .rsp_last    (rsp_ch.last)
);

`default_nettype wire
